/* rtl/nlwt_pkg.sv */
// Package for the nearest leaf weighted tree block.
// It holds field widths, reset values, register addresses and request codes.
// It depends on nothing.
package nlwt_pkg;

  localparam int unsigned DefMaxNodes   = 64;
  localparam int unsigned DefWeightBits = 16;

  localparam int unsigned NodeFieldBits   = 6;
  localparam int unsigned WeightFieldBits = 16;
  localparam int unsigned CountBits       = 7;
  localparam int unsigned PaddrBits       = 3;
  localparam int unsigned PdataBits       = 32;

  localparam logic [CountBits-1:0] NodeCountRst = 7'd64;
  localparam logic [PaddrBits-1:0] AddrNodeCount = 3'd0;

  typedef enum logic {
    ACT_EDGE  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

endpackage

/* rtl/nlwt_if.sv */
// Request and result channel interfaces of the nearest leaf weighted tree block.
// They depend on nlwt_pkg for the field widths.
interface nlwt_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [nlwt_pkg::NodeFieldBits-1:0]   node_a;
  logic [nlwt_pkg::NodeFieldBits-1:0]   node_b;
  logic [nlwt_pkg::WeightFieldBits-1:0] weight;

  modport source (output valid, action, node_a, node_b, weight, input ready);
  modport sink   (input valid, action, node_a, node_b, weight, output ready);
endinterface

interface nlwt_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [nlwt_pkg::NodeFieldBits-1:0] nearest_leaf;
  logic                               no_leaf;

  modport source (output valid, nearest_leaf, no_leaf, input ready);
  modport sink   (input valid, nearest_leaf, no_leaf, output ready);
endinterface

/* rtl/nlwt_ram.sv */
// Single write port, single read port memory with a registered read.
// It is used for the weight matrix and for the walk stack; no dependencies.
module nlwt_ram #(
  parameter int unsigned Depth    = 64,
  parameter int unsigned DataBits = 16,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [DataBits-1:0] wdata_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [DataBits-1:0] rdata_o
);

  logic [DataBits-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/nlwt_cfg.sv */
// APB-style configuration register file holding the node count.
// It depends on nlwt_pkg for widths, addresses and the reset value.
module nlwt_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [nlwt_pkg::PaddrBits-1:0]       paddr,
  input  logic [nlwt_pkg::PdataBits-1:0]       pwdata,
  output logic [nlwt_pkg::PdataBits-1:0]       prdata,
  output logic                                 pready,
  output logic [nlwt_pkg::CountBits-1:0]       node_count_o
);

  logic [nlwt_pkg::CountBits-1:0] node_count_q, node_count_d;

  assign pready = 1'b1;

  always_comb begin
    node_count_d = node_count_q;
    if (psel && penable && pwrite && (paddr == nlwt_pkg::AddrNodeCount)) begin
      node_count_d = pwdata[nlwt_pkg::CountBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= nlwt_pkg::NodeCountRst;
    end else begin
      node_count_q <= node_count_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == nlwt_pkg::AddrNodeCount) begin
      prdata = nlwt_pkg::PdataBits'(node_count_q);
    end
  end

  assign node_count_o = node_count_q;

endmodule

/* rtl/nearest_leaf_weighted_tree.sv */
// Channel  Dir  Carries
// req_i    in   action, node_a, node_b, weight
// rsp_o    out  nearest_leaf, no_leaf (one per query)
// apb      in   node_count register at byte address 0
//
// After reset a clearing pass writes zero to every entry of the weight matrix.
// An edge request makes two writes to the single matrix write port, in S_WR1 and S_WR2.
// A query reads the matrix one entry per cycle while it scans a row, for the start node and each visited node.
// A finished result waits in the output register while the next request is taken.
// Top level of the nearest leaf weighted tree block; uses nlwt_pkg, nlwt_if, nlwt_ram, nlwt_cfg.
module nearest_leaf_weighted_tree #(
  parameter int unsigned MAX_NODES   = nlwt_pkg::DefMaxNodes,
  parameter int unsigned WEIGHT_BITS = nlwt_pkg::DefWeightBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  nlwt_req_if.sink                       req_i,
  nlwt_rsp_if.source                     rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nlwt_pkg::PaddrBits-1:0] paddr,
  input  logic [nlwt_pkg::PdataBits-1:0] pwdata,
  output logic [nlwt_pkg::PdataBits-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned NB     = $clog2(MAX_NODES);
  localparam int unsigned CB     = $clog2(MAX_NODES + 1);
  localparam int unsigned DB     = WEIGHT_BITS + NB;
  localparam int unsigned Depth  = MAX_NODES * MAX_NODES;
  localparam int unsigned AB     = $clog2(Depth);
  localparam int unsigned FB     = NB + CB + DB + 1;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_WR1  = 8'b0000_0100,
    S_WR2  = 8'b0000_1000,
    S_CNT  = 8'b0001_0000,
    S_SCAN = 8'b0010_0000,
    S_POP  = 8'b0100_0000,
    S_RES  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [AB-1:0] clr_q, clr_d;
  logic [NB-1:0] u_q, u_d, b_q, b_d, pc_q, pc_d, depth_q, depth_d, best_q, best_d;
  logic [WEIGHT_BITS-1:0] w_q, w_d;
  logic [CB-1:0] c_q, c_d;
  logic p_q, p_d, br_q, br_d, found_q, found_d;
  logic [1:0] cnt_q, cnt_d;
  logic [DB-1:0] dist_q, dist_d, bestd_q, bestd_d;
  logic [MAX_NODES-1:0] vis_q, vis_d;
  logic ovalid_q, ovalid_d, onl_q, onl_d;
  logic [nlwt_pkg::NodeFieldBits-1:0] oleaf_q, oleaf_d;

  logic [nlwt_pkg::CountBits-1:0] node_count;
  logic [CB-1:0] n_eff;

  logic adj_we;
  logic [AB-1:0] adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_wdata, adj_rd;
  logic stk_we;
  logic [NB-1:0] stk_raddr;
  logic [FB-1:0] stk_wdata, stk_rd;
  logic hit;

  nlwt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .node_count_o(node_count)
  );

  nlwt_ram #(.Depth(Depth), .DataBits(WEIGHT_BITS)) u_adj (
    .clk_i, .we_i(adj_we), .waddr_i(adj_waddr), .wdata_i(adj_wdata),
    .raddr_i(adj_raddr), .rdata_o(adj_rd)
  );

  nlwt_ram #(.Depth(MAX_NODES), .DataBits(FB)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(depth_q), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

  assign n_eff = (int'(node_count) > int'(MAX_NODES)) ? CB'(MAX_NODES) : CB'(node_count);
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = ovalid_q;
  assign rsp_o.nearest_leaf = oleaf_q;
  assign rsp_o.no_leaf = onl_q;
  assign stk_raddr = depth_q - NB'(1);
  assign hit = p_q && (adj_rd != '0) && !vis_q[pc_q] && (int'(depth_q) < int'(MAX_NODES) - 1);

  always_comb begin
    state_d = state_q;  clr_d = clr_q;  u_d = u_q;  b_d = b_q;  w_d = w_q;
    c_d = c_q;  p_d = p_q;  pc_d = pc_q;  cnt_d = cnt_q;  br_d = br_q;
    dist_d = dist_q;  depth_d = depth_q;  vis_d = vis_q;
    best_d = best_q;  bestd_d = bestd_q;  found_d = found_q;
    ovalid_d = ovalid_q;  oleaf_d = oleaf_q;  onl_d = onl_q;
    adj_we = 1'b0;  adj_waddr = clr_q;  adj_wdata = '0;
    adj_raddr = AB'(int'(u_q) * int'(MAX_NODES) + int'(c_q));
    stk_we = 1'b0;
    stk_wdata = {u_q, CB'(pc_q) + CB'(1), dist_q, 1'b1};

    if (ovalid_q && rsp_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        adj_we = 1'b1;
        clr_d = clr_q + AB'(1);
        if (int'(clr_q) == int'(Depth) - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.action == nlwt_pkg::ACT_QUERY) begin
            found_d = 1'b0;
            best_d = '0;
            bestd_d = '1;
            u_d = NB'(req_i.node_a);
            c_d = '0;
            p_d = 1'b0;
            cnt_d = '0;
            state_d = (int'(req_i.node_a) >= int'(n_eff)) ? S_RES : S_CNT;
          end else if ((int'(req_i.node_a) < int'(MAX_NODES)) &&
                       (int'(req_i.node_b) < int'(MAX_NODES))) begin
            u_d = NB'(req_i.node_a);
            b_d = NB'(req_i.node_b);
            w_d = WEIGHT_BITS'(req_i.weight);
            state_d = S_WR1;
          end
        end
      end
      S_WR1: begin
        adj_we = 1'b1;
        adj_waddr = AB'(int'(u_q) * int'(MAX_NODES) + int'(b_q));
        adj_wdata = w_q;
        state_d = S_WR2;
      end
      S_WR2: begin
        adj_we = 1'b1;
        adj_waddr = AB'(int'(b_q) * int'(MAX_NODES) + int'(u_q));
        adj_wdata = w_q;
        state_d = S_IDLE;
      end
      S_CNT: begin
        if (p_q && (adj_rd != '0) && (cnt_q != 2'd2)) begin
          cnt_d = cnt_q + 2'd1;
        end
        if (c_q < n_eff) begin
          p_d = 1'b1;
          pc_d = NB'(c_q);
          c_d = c_q + CB'(1);
        end else begin
          p_d = 1'b0;
          if (!p_q) begin
            if ((cnt_q == 2'd1) && (u_q != '0)) begin
              found_d = 1'b1;
              best_d = u_q;
              state_d = S_RES;
            end else begin
              vis_d = '0;
              vis_d[u_q] = 1'b1;
              depth_d = '0;
              dist_d = '0;
              br_d = 1'b0;
              c_d = '0;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          stk_we = 1'b1;
          u_d = pc_q;
          dist_d = dist_q + DB'(adj_rd);
          br_d = 1'b0;
          c_d = '0;
          p_d = 1'b0;
          depth_d = depth_q + NB'(1);
          vis_d[pc_q] = 1'b1;
        end else if (c_q < n_eff) begin
          p_d = 1'b1;
          pc_d = NB'(c_q);
          c_d = c_q + CB'(1);
        end else begin
          p_d = 1'b0;
          if (!br_q && (u_q != '0)) begin
            if (!found_q || (dist_q < bestd_q)) begin
              found_d = 1'b1;
              bestd_d = dist_q;
              best_d = u_q;
            end else if ((dist_q == bestd_q) && (u_q < best_q)) begin
              best_d = u_q;
            end
          end
          state_d = (depth_q == '0) ? S_RES : S_POP;
        end
      end
      S_POP: begin
        {u_d, c_d, dist_d, br_d} = stk_rd;
        depth_d = depth_q - NB'(1);
        p_d = 1'b0;
        state_d = S_SCAN;
      end
      S_RES: begin
        if (!ovalid_q || rsp_o.ready) begin
          ovalid_d = 1'b1;
          oleaf_d = found_q ? nlwt_pkg::NodeFieldBits'(best_q) : '0;
          onl_d = !found_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      p_q <= 1'b0;
      found_q <= 1'b0;
      ovalid_q <= 1'b0;
      vis_q <= '0;
      depth_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      p_q <= p_d;
      found_q <= found_d;
      ovalid_q <= ovalid_d;
      vis_q <= vis_d;
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    b_q <= b_d;
    w_q <= w_d;
    c_q <= c_d;
    pc_q <= pc_d;
    cnt_q <= cnt_d;
    br_q <= br_d;
    dist_q <= dist_d;
    best_q <= best_d;
    bestd_q <= bestd_d;
    oleaf_q <= oleaf_d;
    onl_q <= onl_d;
  end

endmodule
